### rtl/scba_pkg.sv
package scba_pkg;

	// Commands
	localparam logic [1:0] CMD_ALLOC       = 2'd0;
	localparam logic [1:0] CMD_RELEASE     = 2'd1;
	localparam logic [1:0] CMD_RELEASE_ALL = 2'd2;

	localparam int TABLE_POOLS = 10;

	// Buffer sizes of the fixed pools; the largest pool is sized by the top level
	localparam logic [19:0] POOL_BYTES [TABLE_POOLS-1] = '{
		20'd30, 20'd60, 20'd200, 20'd600, 20'd1050,
		20'd3000, 20'd16000, 20'd30000, 20'd66000
	};

	localparam logic [7:0] POOL_COUNT [TABLE_POOLS] = '{
		8'd100, 8'd100, 8'd100, 8'd40, 8'd20, 8'd20, 8'd3, 8'd3, 8'd2, 8'd1
	};

	typedef struct packed {
		logic [1:0]  command;
		logic [19:0] request_bytes;
		logic [3:0]  release_pool;
		logic [6:0]  release_slot;
	} req_t;

	typedef struct packed {
		logic        granted;
		logic [3:0]  granted_pool;
		logic [6:0]  granted_slot;
		logic [8:0]  free_count;
	} rsp_t;

	// Slots of a pool, capped at the row width
	function automatic logic [7:0] pool_count(input logic [3:0] p, input int max_slots);
		logic [7:0] n;
		n = 8'd0;
		if (32'(p) < TABLE_POOLS) begin
			n = POOL_COUNT[p];
			if (32'(n) > max_slots) begin
				n = 8'(max_slots);
			end
		end
		return n;
	endfunction

	function automatic logic [19:0] pool_bytes(input logic [3:0] p, input int image_bytes);
		logic [19:0] b;
		if (32'(p) < TABLE_POOLS - 1) begin
			b = POOL_BYTES[p];
		end else begin
			b = 20'(image_bytes);
		end
		return b;
	endfunction

	function automatic int total_slots(input int num_pools, input int max_slots);
		int t;
		t = 0;
		for (int p = 0; p < num_pools; p++) begin
			t += 32'(pool_count(4'(p), max_slots));
		end
		return t;
	endfunction

endpackage

### rtl/size_class_buffer_allocator_top.sv
// Channel   | Handshake             | Payload          | Notes
// ----------+-----------------------+------------------+---------------------------------
// request   | start, busy           | request (req_t)  | taken at edge with start && !busy
// result    | done                  | result (rsp_t)   | one-cycle strobe, no back-pressure
//
// Allocate: busy while pools are visited from pool 0 until a hit or the last pool;
//   the pool loop runs on a single rotating priority encoder, one pool a cycle.
// Release one / release all / unknown command: handled in the apply state, no pool search.
// done pulses in the first cycle after busy drops; the next request may be
//   taken in that same cycle.
// Reset (arst_n low) frees every slot at once and zeroes the search pointers;
//   no clearing pass.
// The receiver cannot stall: each result is flagged by done for exactly one cycle.
module size_class_buffer_allocator_top #(
	parameter int NUM_POOLS   = 10,
	parameter int MAX_SLOTS   = 128,
	parameter int IMAGE_BYTES = 541238
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  scba_pkg::req_t  request,
	output logic            busy,
	output logic            done,
	output scba_pkg::rsp_t  result
);

	import scba_pkg::*;

	localparam int PW = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
	localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam logic [8:0]    TOTAL     = 9'(total_slots(NUM_POOLS, MAX_SLOTS));
	localparam logic [PW-1:0] LAST_POOL = PW'(NUM_POOLS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_APPLY
	} state_t;

	state_t               state_q;
	req_t                 req_q;      // request held while it is worked on
	rsp_t                 res_q;
	logic                 done_q;
	logic [PW-1:0]        pool_q;     // pool under search
	logic [8:0]           free_q;
	logic [MAX_SLOTS-1:0] used_q  [NUM_POOLS];  // slot bitmap, one row per pool
	logic [SW-1:0]        start_q [NUM_POOLS];  // next-fit pointer per pool

	// Current pool
	logic [3:0]    pool_w;
	logic [CW-1:0] cnt;
	logic          considered;
	logic [SW-1:0] start_eff;
	logic [7:0]    start_inc;
	logic [SW-1:0] start_nxt;
	logic          found;
	logic [SW-1:0] slot;

	// Release path
	logic [7:0]    rel_cnt;
	logic          rel_ok;

	// Strobes
	logic          alloc_hit;
	logic          adv_en;
	logic          rel_en;
	logic          all_en;
	logic          finish;
	logic [8:0]    free_nxt;

	assign pool_w     = 4'(pool_q);
	assign cnt        = CW'(pool_count(pool_w, MAX_SLOTS));
	// a pool is eligible only when the request fits strictly inside its buffers
	assign considered = (cnt != '0) &&
		(req_q.request_bytes < pool_bytes(pool_w, IMAGE_BYTES));

	always_comb begin
		start_eff = start_q[pool_q];
		if (8'(start_eff) >= 8'(cnt)) begin
			start_eff = '0;
		end
		start_inc = 8'(start_eff) + 8'd1;
		start_nxt = (start_inc >= 8'(cnt)) ? '0 : SW'(start_inc);
	end

	scba_find #(
		.MAX_SLOTS (MAX_SLOTS),
		.SW        (SW),
		.CW        (CW)
	) u_find (
		.used  (used_q[pool_q]),
		.count (cnt),
		.start (start_eff),
		.found (found),
		.slot  (slot)
	);

	// Out-of-range pool or slot is dropped; freeing a free slot is a no-op
	assign rel_cnt = pool_count(req_q.release_pool, MAX_SLOTS);
	assign rel_ok  = (5'(req_q.release_pool) < 5'(NUM_POOLS)) &&
		({1'b0, req_q.release_slot} < rel_cnt) &&
		used_q[req_q.release_pool[PW-1:0]][req_q.release_slot[SW-1:0]];

	assign alloc_hit = (state_q == ST_SEARCH) && considered && found;
	assign adv_en    = (state_q == ST_SEARCH) && considered;
	assign rel_en    = (state_q == ST_APPLY) && (req_q.command == CMD_RELEASE) && rel_ok;
	assign all_en    = (state_q == ST_APPLY) && (req_q.command == CMD_RELEASE_ALL);
	assign finish    = ((state_q == ST_SEARCH) && (alloc_hit || (pool_q == LAST_POOL))) ||
		(state_q == ST_APPLY);

	always_comb begin
		free_nxt = free_q;
		if (all_en) begin
			free_nxt = TOTAL;
		end else if (rel_en) begin
			free_nxt = free_q + 9'd1;
		end else if (alloc_hit && (free_q != '0)) begin
			free_nxt = free_q - 9'd1;
		end
	end

	// Slot bitmap and search pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_POOLS; p++) begin
				used_q[p]  <= '0;
				start_q[p] <= '0;
			end
		end else begin
			if (all_en) begin
				for (int p = 0; p < NUM_POOLS; p++) begin
					used_q[p] <= '0;
				end
			end else if (rel_en) begin
				used_q[req_q.release_pool[PW-1:0]][req_q.release_slot[SW-1:0]] <= 1'b0;
			end else if (alloc_hit) begin
				used_q[pool_q][slot] <= 1'b1;
			end
			// pointer moves on every considered pool, hit or miss
			if (adv_en) begin
				start_q[pool_q] <= start_nxt;
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			pool_q  <= '0;
			free_q  <= TOTAL;
		end else begin
			done_q <= 1'b0;
			free_q <= free_nxt;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						pool_q  <= '0;
						state_q <= (request.command == CMD_ALLOC) ? ST_SEARCH : ST_APPLY;
					end
				end
				ST_SEARCH: begin
					if (finish) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						pool_q <= pool_q + 1'b1;
					end
				end
				ST_APPLY: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= request;
		end
		if (finish) begin
			res_q.granted      <= alloc_hit;
			res_q.granted_pool <= alloc_hit ? 4'(pool_q) : 4'd0;
			res_q.granted_slot <= alloc_hit ? 7'(slot) : 7'd0;
			res_q.free_count   <= free_nxt;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= TOTAL)
		else $error("free count above pool total");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request taken without going busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) && !busy))
		else $error("result strobe not at end of work");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.granted) |-> ((result.granted_pool == 4'd0) &&
			(result.granted_slot == 7'd0)))
		else $error("miss reports a pool or slot");

	a_grant_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.granted) |-> (5'(result.granted_pool) < 5'(NUM_POOLS)))
		else $error("grant from nonexistent pool");

endmodule

### rtl/scba_find.sv
// Rotating first-free search over one pool's slot bitmap
module scba_find #(
	parameter int MAX_SLOTS = 128,
	parameter int SW        = 7,
	parameter int CW        = 8
) (
	input  logic [MAX_SLOTS-1:0] used,
	input  logic [CW-1:0]        count,
	input  logic [SW-1:0]        start,
	output logic                 found,
	output logic [SW-1:0]        slot
);

	logic [MAX_SLOTS-1:0] free_v;
	logic [MAX_SLOTS-1:0] hi_v;
	logic [MAX_SLOTS-1:0] pick;
	logic [MAX_SLOTS-1:0] low;

	always_comb begin
		for (int i = 0; i < MAX_SLOTS; i++) begin
			free_v[i] = !used[i] && (CW'(i) < count);
			hi_v[i]   = free_v[i] && (SW'(i) >= start);
		end
	end

	// wrap: fall back to the lowest free slot when nothing at or above start
	assign pick  = (|hi_v) ? hi_v : free_v;
	assign low   = pick & (~pick + 1'b1);
	assign found = |free_v;

	always_comb begin
		slot = '0;
		for (int i = 0; i < MAX_SLOTS; i++) begin
			if (low[i]) begin
				slot = slot | SW'(i);
			end
		end
	end

endmodule
